/* src/calendar_field_adjust_defines.svh */
// Assertion macros for the calendar field adjuster.
// Used by calendar_field_adjust; expects clk and rst_n in scope.
`ifndef CALENDAR_FIELD_ADJUST_DEFINES_SVH
`define CALENDAR_FIELD_ADJUST_DEFINES_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, ignored while reset is asserted.
`define CFA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, ignored while reset is asserted.
`define CFA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define CFA_ASSERT_IMP(lbl, ante, cons, msg)
`define CFA_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

/* src/cfa_pkg.sv */
// Types, constants and month-length functions for the calendar field adjuster.
// No dependencies; imported by calendar_field_adjust.
`timescale 1ns / 1ps
`default_nettype none

package cfa_pkg;

  typedef enum logic [1:0] {
    MODE_INC  = 2'd0,
    MODE_DEC  = 2'd1,
    MODE_LOAD = 2'd2,
    MODE_HOLD = 2'd3
  } cfa_mode_t;

  typedef enum logic [2:0] {
    FIELD_HOUR   = 3'd0,
    FIELD_MINUTE = 3'd1,
    FIELD_SECOND = 3'd2,
    FIELD_YEAR   = 3'd3,
    FIELD_MONTH  = 3'd4,
    FIELD_DAY    = 3'd5
  } cfa_field_t;

  localparam logic [5:0] SECOND_MAX = 6'd59;
  localparam logic [5:0] MINUTE_MAX = 6'd59;
  localparam logic [4:0] HOUR_MAX   = 5'd23;
  localparam logic [3:0] MONTH_MAX  = 4'd11;
  localparam logic [9:0] YEAR_MAX   = 10'd999;

  localparam logic [3:0] MONTH_FEB = 4'd1;
  localparam logic [3:0] MONTH_APR = 4'd3;
  localparam logic [3:0] MONTH_JUN = 4'd5;
  localparam logic [3:0] MONTH_SEP = 4'd8;
  localparam logic [3:0] MONTH_NOV = 4'd10;

  localparam logic [9:0] YEAR_RESET = 10'd120;

  typedef struct packed {
    cfa_mode_t   mode;
    logic [2:0]  field_sel;
    logic [5:0]  load_second;
    logic [5:0]  load_minute;
    logic [4:0]  load_hour;
    logic [4:0]  load_day;
    logic [3:0]  load_month;
    logic [9:0]  load_year;
  } cfa_in_t;

  typedef struct packed {
    logic [5:0]  out_second;
    logic [5:0]  out_minute;
    logic [4:0]  out_hour;
    logic [4:0]  out_day;
    logic [3:0]  out_month;
    logic [9:0]  out_year;
  } cfa_out_t;

  // Offsets from 1900 are 0..1023, so years run 1900..2923. Century years sit
  // at offsets that are multiples of 100; those divisible by 400 are 2000,
  // 2400 and 2800. 1900 is a multiple of 4, so the low bits test the rest.
  function automatic logic is_leap(input logic [9:0] off);
    logic century;
    logic quad_century;
    century = (off == 10'd0)   || (off == 10'd100) || (off == 10'd200) ||
              (off == 10'd300) || (off == 10'd400) || (off == 10'd500) ||
              (off == 10'd600) || (off == 10'd700) || (off == 10'd800) ||
              (off == 10'd900) || (off == 10'd1000);
    quad_century = (off == 10'd100) || (off == 10'd500) || (off == 10'd900);
    return quad_century || ((off[1:0] == 2'b00) && !century);
  endfunction

  // Months 12 to 15 count as 31-day months.
  function automatic logic [4:0] month_len(input logic [3:0] mon, input logic [9:0] off);
    logic [4:0] len;
    if (mon == MONTH_APR || mon == MONTH_JUN || mon == MONTH_SEP || mon == MONTH_NOV) begin
      len = 5'd30;
    end else if (mon == MONTH_FEB) begin
      len = is_leap(off) ? 5'd29 : 5'd28;
    end else begin
      len = 5'd31;
    end
    return len;
  endfunction

endpackage

`default_nettype wire

/* src/calendar_field_adjust.sv */
// Calendar field adjuster: second, minute, hour, day, month and year offset.
// A request passes the input register and then the calendar register before
// out_valid rises and the result can be taken; out_stall can hold either stage.
// Throughput: one request per cycle while out_stall stays low, set by the
// combinational compare-and-wrap update of the calendar register.
// Reset (rst_n low, synchronous): both stages empty, calendar 00:00:00,
// day 1, January, year offset 120 (2020).
`timescale 1ns / 1ps
`default_nettype none
`include "calendar_field_adjust_defines.svh"

module calendar_field_adjust (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             in_valid,
  output logic            in_stall,
  input  wire cfa_pkg::cfa_in_t  in_data,
  output logic            out_valid,
  input  wire             out_stall,
  output cfa_pkg::cfa_out_t out_data
);

  import cfa_pkg::*;

  // Input stage: holds one request until the calendar stage can take it.
  logic     s1_vld_r, s1_vld_nxt;
  cfa_in_t  s1_data_r;
  logic     s1_adv;
  logic     s1_fire;
  logic     in_fire;

  // Calendar stage: the calendar register doubles as the result register.
  logic     out_vld_r, out_vld_nxt;
  cfa_out_t cal_r, cal_nxt;
  logic [4:0] cur_len;

  // Advance the input stage when the result slot is empty or being drained.
  assign s1_adv   = !out_vld_r || !out_stall;
  assign s1_fire  = s1_vld_r && s1_adv;
  assign in_stall = s1_vld_r && !s1_adv;
  assign in_fire  = in_valid && !in_stall;

  assign s1_vld_nxt  = in_fire || (s1_vld_r && !s1_adv);
  assign out_vld_nxt = s1_fire || (out_vld_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
    end
  end

  // Payload register: load on acceptance only, no reset needed.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_data_r <= in_data;
    end
  end

  // Length of the current month, from the stored month and year.
  assign cur_len = month_len(cal_r.out_month, cal_r.out_year);

  // Next calendar: one field steps up or down with wrap, all fields load, or nothing changes.
  always_comb begin
    cal_nxt = cal_r;
    unique case (s1_data_r.mode)
      MODE_LOAD: begin
        cal_nxt.out_second = s1_data_r.load_second;
        cal_nxt.out_minute = s1_data_r.load_minute;
        cal_nxt.out_hour   = s1_data_r.load_hour;
        cal_nxt.out_day    = s1_data_r.load_day;
        cal_nxt.out_month  = s1_data_r.load_month;
        cal_nxt.out_year   = s1_data_r.load_year;
      end
      MODE_INC: begin
        // A field at its limit goes to zero; above it, count on and wrap.
        unique case (s1_data_r.field_sel)
          FIELD_HOUR:   cal_nxt.out_hour   = (cal_r.out_hour == HOUR_MAX) ?
                                             5'd0 : cal_r.out_hour + 5'd1;
          FIELD_MINUTE: cal_nxt.out_minute = (cal_r.out_minute == MINUTE_MAX) ?
                                             6'd0 : cal_r.out_minute + 6'd1;
          FIELD_SECOND: cal_nxt.out_second = (cal_r.out_second == SECOND_MAX) ?
                                             6'd0 : cal_r.out_second + 6'd1;
          FIELD_YEAR:   cal_nxt.out_year   = (cal_r.out_year == YEAR_MAX) ?
                                             10'd0 : cal_r.out_year + 10'd1;
          FIELD_MONTH:  cal_nxt.out_month  = (cal_r.out_month == MONTH_MAX) ?
                                             4'd0 : cal_r.out_month + 4'd1;
          // Day at or past month end restarts at the first.
          FIELD_DAY:    cal_nxt.out_day    = (cal_r.out_day >= cur_len) ?
                                             5'd1 : cal_r.out_day + 5'd1;
          default: ;
        endcase
      end
      MODE_DEC: begin
        // Zero goes to the limit; anything else counts down.
        unique case (s1_data_r.field_sel)
          FIELD_HOUR:   cal_nxt.out_hour   = (cal_r.out_hour == 5'd0) ?
                                             HOUR_MAX : cal_r.out_hour - 5'd1;
          FIELD_MINUTE: cal_nxt.out_minute = (cal_r.out_minute == 6'd0) ?
                                             MINUTE_MAX : cal_r.out_minute - 6'd1;
          FIELD_SECOND: cal_nxt.out_second = (cal_r.out_second == 6'd0) ?
                                             SECOND_MAX : cal_r.out_second - 6'd1;
          FIELD_YEAR:   cal_nxt.out_year   = (cal_r.out_year == 10'd0) ?
                                             YEAR_MAX : cal_r.out_year - 10'd1;
          FIELD_MONTH:  cal_nxt.out_month  = (cal_r.out_month == 4'd0) ?
                                             MONTH_MAX : cal_r.out_month - 4'd1;
          // The first steps back to month end; day zero wraps within 5 bits.
          FIELD_DAY:    cal_nxt.out_day    = (cal_r.out_day == 5'd1) ?
                                             cur_len : cal_r.out_day - 5'd1;
          default: ;
        endcase
      end
      MODE_HOLD: ;
      default: ;
    endcase
  end

  // Update the calendar and raise the result together, so the presented
  // result is always the calendar after the latest request.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r          <= 1'b0;
      cal_r.out_second   <= 6'd0;
      cal_r.out_minute   <= 6'd0;
      cal_r.out_hour     <= 5'd0;
      cal_r.out_day      <= 5'd1;
      cal_r.out_month    <= 4'd0;
      cal_r.out_year     <= YEAR_RESET;
    end else begin
      out_vld_r <= out_vld_nxt;
      if (s1_fire) begin
        cal_r <= cal_nxt;
      end
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = cal_r;

  // Stall the input only while a request waits in the input stage.
  `CFA_ASSERT_IMP(a_stall_needs_item, in_stall, s1_vld_r, "input stalled with empty stage")
  // A new result appears only after the input stage has handed one over.
  `CFA_ASSERT_IMP(a_result_has_source, $rose(out_vld_r), $past(s1_vld_r), "result without request")
  // A day increment never leaves day zero behind.
  `CFA_ASSERT_NXT(a_day_inc_nonzero,
    s1_fire && s1_data_r.mode == MODE_INC && s1_data_r.field_sel == FIELD_DAY,
    cal_r.out_day != 5'd0, "day increment gave day zero")
  // A request with the hold code leaves the calendar untouched.
  `CFA_ASSERT_NXT(a_hold_keeps_cal, s1_fire && s1_data_r.mode == MODE_HOLD,
    $stable(cal_r), "hold request changed calendar")

endmodule

`default_nettype wire

/* sim/tb_top.sv */
// Self-checking testbench for calendar_field_adjust: random and directed requests,
// a predictor of the calendar and a field-by-field result check.
// Depends on cfa_pkg and the calendar_field_adjust RTL.
`timescale 1ns / 1ps

module tb_top;
  import cfa_pkg::*;

  // Selector codes with no field behind them; the block must leave the calendar alone.
  localparam logic [2:0] FIELD_SPARE_LO = 3'd6;
  localparam logic [2:0] FIELD_SPARE_HI = 3'd7;

  localparam int unsigned BASE_YEAR       = 1900;
  localparam int          FIRST_BATCH     = 350;
  localparam int          SECOND_BATCH    = 250;
  localparam int          HOLD_OFF_AFTER  = 150;  // results seen before the long hold-off
  localparam int          HOLD_OFF_CYCLES = 300;
  localparam int          SETTLE_CYCLES   = 8;    // pipeline is two deep; allow a margin

  typedef struct {
    cfa_in_t     req;
    int unsigned gap;  // idle cycles before this request is offered
  } pending_request_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  cfa_in_t  in_data = '0;
  logic     in_stall;
  logic     out_valid;
  logic     out_stall = 1'b0;
  cfa_out_t out_data;

  // 20 ns period
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  calendar_field_adjust uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  pending_request_t request_backlog_q[$];
  cfa_out_t         expected_calendar_q[$];
  int               mismatch_count = 0;
  int               results_seen = 0;
  int               idle_stretch_left = 0;  // requests still to go without any gap
  logic             hold_off = 1'b0;

  // Predicted calendar, reset to 00:00:00 on 1 January 2020
  logic [5:0] cal_sec  = '0;
  logic [5:0] cal_min  = '0;
  logic [4:0] cal_hour = '0;
  logic [4:0] cal_day  = 5'd1;
  logic [3:0] cal_mon  = '0;
  logic [9:0] cal_year = YEAR_RESET;

  //--------------------------------------------------------------------------
  // Predictor
  //--------------------------------------------------------------------------

  // Month length in days; months 12 to 15 fall through to 31 days.
  function automatic logic [4:0] days_in_month(input logic [3:0] mon, input logic [9:0] yoff);
    int unsigned yr;
    logic        leap;
    yr   = yoff + BASE_YEAR;
    leap = (yr % 400 == 0) || ((yr % 4 == 0) && (yr % 100 != 0));
    case (mon)
      MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: return 5'd30;
      MONTH_FEB: return leap ? 5'd29 : 5'd28;
      default:   return 5'd31;
    endcase
  endfunction

  // Apply one accepted request to the predicted calendar and queue the fields
  // the block should report for it. Fields other than the day count on above
  // their limit and wrap at the top of their width; only the exact limit wraps to zero.
  task automatic apply_request(input cfa_in_t req);
    cfa_out_t   res;
    logic [4:0] len;
    len = days_in_month(cal_mon, cal_year);
    case (req.mode)
      MODE_LOAD: begin
        cal_sec  = req.load_second;
        cal_min  = req.load_minute;
        cal_hour = req.load_hour;
        cal_day  = req.load_day;
        cal_mon  = req.load_month;
        cal_year = req.load_year;
      end
      MODE_INC: begin
        case (req.field_sel)
          FIELD_HOUR:   cal_hour = (cal_hour == HOUR_MAX)   ? '0 : cal_hour + 5'd1;
          FIELD_MINUTE: cal_min  = (cal_min  == MINUTE_MAX) ? '0 : cal_min + 6'd1;
          FIELD_SECOND: cal_sec  = (cal_sec  == SECOND_MAX) ? '0 : cal_sec + 6'd1;
          FIELD_YEAR:   cal_year = (cal_year == YEAR_MAX)   ? '0 : cal_year + 10'd1;
          FIELD_MONTH:  cal_mon  = (cal_mon  == MONTH_MAX)  ? '0 : cal_mon + 4'd1;
          // any day at or past the month's end rolls to the first
          FIELD_DAY:    cal_day  = (cal_day >= len) ? 5'd1 : cal_day + 5'd1;
          default: ;
        endcase
      end
      MODE_DEC: begin
        case (req.field_sel)
          FIELD_HOUR:   cal_hour = (cal_hour == '0) ? HOUR_MAX   : cal_hour - 5'd1;
          FIELD_MINUTE: cal_min  = (cal_min  == '0) ? MINUTE_MAX : cal_min - 6'd1;
          FIELD_SECOND: cal_sec  = (cal_sec  == '0) ? SECOND_MAX : cal_sec - 6'd1;
          FIELD_YEAR:   cal_year = (cal_year == '0) ? YEAR_MAX   : cal_year - 10'd1;
          FIELD_MONTH:  cal_mon  = (cal_mon  == '0) ? MONTH_MAX  : cal_mon - 4'd1;
          // day 0 is not the first, so it simply wraps to 31 in five bits
          FIELD_DAY:    cal_day  = (cal_day == 5'd1) ? len : cal_day - 5'd1;
          default: ;
        endcase
      end
      default: ;  // hold: calendar untouched, fields still reported
    endcase
    res.out_second = cal_sec;
    res.out_minute = cal_min;
    res.out_hour   = cal_hour;
    res.out_day    = cal_day;
    res.out_month  = cal_mon;
    res.out_year   = cal_year;
    expected_calendar_q.push_back(res);
  endtask

  //--------------------------------------------------------------------------
  // Checking
  //--------------------------------------------------------------------------

  task automatic report_mismatch(input string what);
    $display("[%0t] ERROR: %s", $time, what);
    mismatch_count++;
  endtask

  task automatic compare_field(input string name, input int got, input int want);
    if (got != want)
      report_mismatch($sformatf("%s: got %0d, want %0d", name, got, want));
  endtask

  task automatic check_calendar(input cfa_out_t got);
    cfa_out_t want;
    if (expected_calendar_q.size() == 0) begin
      report_mismatch("result arrived with no request outstanding");
    end else begin
      want = expected_calendar_q.pop_front();
      compare_field("out_second", got.out_second, want.out_second);
      compare_field("out_minute", got.out_minute, want.out_minute);
      compare_field("out_hour",   got.out_hour,   want.out_hour);
      compare_field("out_day",    got.out_day,    want.out_day);
      compare_field("out_month",  got.out_month,  want.out_month);
      compare_field("out_year",   got.out_year,   want.out_year);
    end
  endtask

  //--------------------------------------------------------------------------
  // Driver: offer requests from the backlog, honouring each one's idle gap.
  // Hold the payload while stalled; lower valid only when the backlog is dry
  // or a gap is due.
  //--------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
    end else begin
      if (in_valid && !in_stall)
        apply_request(in_data);
      if (!in_valid || !in_stall) begin
        if (request_backlog_q.size() == 0) begin
          in_valid <= 1'b0;
        end else if (request_backlog_q[0].gap != 0) begin
          in_valid <= 1'b0;
          request_backlog_q[0].gap = request_backlog_q[0].gap - 1;
        end else begin
          in_valid <= 1'b1;
          in_data  <= request_backlog_q[0].req;
          void'(request_backlog_q.pop_front());
        end
      end
    end
  end

  //--------------------------------------------------------------------------
  // Monitor: check every accepted result, then decide the next stall.
  // Mix calm stretches, short stalls and the odd long one.
  //--------------------------------------------------------------------------
  int stall_left = 0;
  int calm_left  = 0;

  always @(posedge clk) begin
    int r;
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
      calm_left  <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        check_calendar(out_data);
        results_seen <= results_seen + 1;
      end
      if (hold_off) begin
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        out_stall  <= 1'b1;
        stall_left <= stall_left - 1;
      end else if (calm_left > 0) begin
        out_stall <= 1'b0;
        calm_left <= calm_left - 1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 8) begin
          out_stall <= 1'b0;
          calm_left <= $urandom_range(20, 60);
        end else if (r < 55) begin
          out_stall <= 1'b0;
        end else if (r < 92) begin
          out_stall  <= 1'b1;
          stall_left <= $urandom_range(0, 2);
        end else begin
          out_stall  <= 1'b1;
          stall_left <= $urandom_range(10, 40);
        end
      end
    end
  end

  // Long receiver hold-off while the sender keeps offering, so the pipeline
  // fills and the block has to stall its input.
  initial begin
    do @(negedge clk); while (results_seen < HOLD_OFF_AFTER);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_OFF_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  //--------------------------------------------------------------------------
  // Stimulus
  //--------------------------------------------------------------------------

  // Mostly back to back, some short gaps, a few long ones, and now and then
  // a run of requests with no gap at all.
  function automatic int unsigned pick_gap();
    int r;
    if (idle_stretch_left > 0) begin
      idle_stretch_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 5) begin
      idle_stretch_left = $urandom_range(20, 50);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic queue_request(input cfa_in_t req);
    pending_request_t p;
    p.req = req;
    p.gap = pick_gap();
    request_backlog_q.push_back(p);
  endtask

  // Adjust one field; the load fields carry random junk the block must ignore.
  task automatic queue_adjust(input cfa_mode_t m, input logic [2:0] f);
    cfa_in_t req;
    req = cfa_in_t'({$urandom, $urandom} >> (64 - $bits(cfa_in_t)));
    req.mode      = m;
    req.field_sel = f;
    queue_request(req);
  endtask

  task automatic queue_load(input int s, input int mi, input int h, input int d,
                            input int mo, input int y);
    cfa_in_t req;
    req = cfa_in_t'({$urandom, $urandom} >> (64 - $bits(cfa_in_t)));
    req.mode        = MODE_LOAD;
    req.load_second = s;
    req.load_minute = mi;
    req.load_hour   = h;
    req.load_day    = d;
    req.load_month  = mo;
    req.load_year   = y;
    queue_request(req);
  endtask

  // Random request: mostly field adjustments, a good share of loads aimed at
  // month ends and leap-year Februaries, and some noise the block must ignore.
  task automatic queue_random_request();
    cfa_in_t req;
    int      r;
    req = cfa_in_t'({$urandom, $urandom} >> (64 - $bits(cfa_in_t)));
    r = $urandom_range(0, 99);
    if (r < 70) begin
      req.mode      = $urandom_range(0, 1) ? MODE_DEC : MODE_INC;
      req.field_sel = $urandom_range(FIELD_HOUR, FIELD_DAY);
    end else if (r < 92) begin
      req.mode = MODE_LOAD;
      // one load in five keeps its raw full-width values
      if ($urandom_range(0, 4) != 0) begin
        req.load_second = $urandom_range(0, SECOND_MAX);
        req.load_minute = $urandom_range(0, MINUTE_MAX);
        req.load_hour   = $urandom_range(0, HOUR_MAX);
        case ($urandom_range(0, 3))
          0:       req.load_day = 5'd1;
          1:       req.load_day = $urandom_range(28, 31);
          default: req.load_day = $urandom_range(1, 31);
        endcase
        req.load_month = ($urandom_range(0, 3) == 0) ? MONTH_FEB
                                                     : $urandom_range(0, MONTH_MAX);
        req.load_year  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 9) * 100
                                                     : $urandom_range(0, YEAR_MAX);
      end
    end else if ($urandom_range(0, 1) != 0) begin
      req.mode = MODE_HOLD;
    end else begin
      req.mode      = $urandom_range(0, 1) ? MODE_DEC : MODE_INC;
      req.field_sel = $urandom_range(0, 1) ? FIELD_SPARE_HI : FIELD_SPARE_LO;
    end
    queue_request(req);
  endtask

  // Wait until nothing is queued, on the wire or awaiting its result.
  task automatic wait_for_drain();
    do @(negedge clk);
    while (request_backlog_q.size() != 0 || in_valid || expected_calendar_q.size() != 0);
  endtask

  initial begin
    // Directed part, starting from the reset calendar
    queue_adjust(MODE_HOLD, FIELD_HOUR);        // reset state reported unchanged
    queue_adjust(MODE_INC, FIELD_SPARE_LO);     // unused selectors change nothing
    queue_adjust(MODE_DEC, FIELD_SPARE_HI);
    queue_adjust(MODE_DEC, FIELD_HOUR);         // zero wraps down to the limit
    queue_adjust(MODE_DEC, FIELD_MINUTE);
    queue_adjust(MODE_DEC, FIELD_SECOND);
    queue_adjust(MODE_DEC, FIELD_MONTH);
    queue_adjust(MODE_DEC, FIELD_DAY);          // first of the month back to its length
    queue_load(0, 0, 0, 0, 0, 0);
    queue_adjust(MODE_DEC, FIELD_YEAR);         // 1900 back to 2899
    queue_adjust(MODE_DEC, FIELD_DAY);          // day zero wraps in five bits
    queue_load(63, 63, 31, 31, 15, 1023);       // every field but the day past its range
    queue_adjust(MODE_INC, FIELD_SECOND);
    queue_adjust(MODE_INC, FIELD_MINUTE);
    queue_adjust(MODE_INC, FIELD_HOUR);
    queue_adjust(MODE_INC, FIELD_YEAR);
    queue_adjust(MODE_INC, FIELD_DAY);          // out-of-range month counts 31 days
    queue_adjust(MODE_INC, FIELD_MONTH);
    queue_load(59, 59, 23, 30, 10, 999);        // every field but the month at its limit
    queue_adjust(MODE_INC, FIELD_DAY);
    queue_adjust(MODE_INC, FIELD_YEAR);
    queue_adjust(MODE_INC, FIELD_HOUR);
    queue_load(30, 30, 12, 29, 1, 100);         // February 2000, a leap century
    queue_adjust(MODE_INC, FIELD_DAY);
    queue_load(30, 30, 12, 1, 1, 0);            // February 1900, no leap day
    queue_adjust(MODE_DEC, FIELD_DAY);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Let the directed part complete before the sender pauses fully idle
    wait_for_drain();
    repeat ($urandom_range(3, 10)) @(negedge clk);

    repeat (FIRST_BATCH) queue_random_request();
    wait_for_drain();
    repeat (SECOND_BATCH) queue_random_request();

    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Ceiling on the run: several times the slowest legal run
  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
